// ===== hw/rtl/htwd_pkg.sv =====
// Shared types, register indexes and constants of the Huffman tree-walk decoder.
package htwd_pkg;

  localparam int TREE_NODES_DEF = 512;
  localparam int IDX_W          = 9;
  localparam int SYM_W          = 8;
  localparam int CFG_IDX_W      = 8;
  localparam int CFG_DATA_W     = 9;
  localparam int PAD_W          = 3;
  localparam int BITS_PER_BYTE  = 8;
  localparam int REM_W          = 4;

  localparam logic [CFG_IDX_W-1:0] REG_PADDING_BITS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ROOT_INDEX   = CFG_IDX_W'(1);

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_STREAM = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [IDX_W-1:0] node_index;
    logic             node_is_leaf;
    logic [SYM_W-1:0] node_symbol;
    logic [IDX_W-1:0] left_child;
    logic [IDX_W-1:0] right_child;
    logic [SYM_W-1:0] stream_byte;
    logic             last_byte;
  } in_item_t;

  typedef struct packed {
    logic [SYM_W-1:0] decoded_symbol;
    logic             last_in_run;
  } out_item_t;

  typedef struct packed {
    logic             leaf;
    logic [SYM_W-1:0] symbol;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
  } node_t;

  localparam int NODE_W = $bits(node_t);

  // Sequencer to output stage: a new symbol, or close of the current byte's run
  typedef struct packed {
    logic             push;
    logic             fin;
    logic [SYM_W-1:0] symbol;
  } emit_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROOT,
    ST_CUR,
    ST_WALK,
    ST_RLEAF,
    ST_FLUSH
  } state_t;

endpackage

// ===== hw/rtl/huffman_tree_walk_decoder.sv =====
// Sequencing: a load item is written on acceptance and leaves the input ready; a stream byte keeps
// the input busy through the root read, a step per decoded bit and the run close, where its last
// symbol goes out. Throughput: one tree node per cycle and one stream bit per cycle after the setup
// reads while no result waits with both output slots full, since each bit needs one dependent node
// table read; such a wait stalls the walk. Reset (rst_n low, synchronous) clears the sequencer,
// registers and output valids; the node table is not cleared and holds garbage until loaded.
module huffman_tree_walk_decoder #(
  parameter int TREE_NODES = htwd_pkg::TREE_NODES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  htwd_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output htwd_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [htwd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [htwd_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import htwd_pkg::*;

  localparam int AW = $clog2(TREE_NODES);

  state_t           state_r, state_nxt;
  logic [PAD_W-1:0] pad_r, pad_nxt;
  logic [IDX_W-1:0] root_r, root_nxt;
  logic [IDX_W-1:0] walk_r, walk_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic             last_r, last_nxt;
  node_t            root_node_r, root_node_nxt;
  logic             rd_oob_r;

  // Node table port signals
  logic              wr_en;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_idx;
  logic [NODE_W-1:0] rd_raw;
  node_t             rd_node;
  node_t             eff_node;
  logic [IDX_W-1:0]  child;
  logic              cur_bit;

  emit_req_t req;
  logic      req_ok;

  htwd_ram #(
    .WIDTH (NODE_W),
    .DEPTH (TREE_NODES)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(in_data.node_index)),
    .wr_data ({in_data.node_is_leaf, in_data.node_symbol,
               in_data.left_child, in_data.right_child}),
    .rd_en   (rd_en),
    .rd_addr (AW'(rd_idx)),
    .rd_data (rd_raw)
  );

  htwd_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .req_ok    (req_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // An index past the table reads as an empty node
  assign rd_node = rd_oob_r ? '0 : node_t'(rd_raw);
  assign cur_bit = byte_r[7];

  // After a leaf the walk restarts at the root, whose contents are already held
  assign eff_node = (state_r == ST_WALK && rd_node.leaf) ? root_node_r : rd_node;
  assign child    = cur_bit ? eff_node.right : eff_node.left;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt     = state_r;
    pad_nxt       = pad_r;
    root_nxt      = root_r;
    walk_nxt      = walk_r;
    byte_nxt      = byte_r;
    rem_nxt       = rem_r;
    last_nxt      = last_r;
    root_node_nxt = root_node_r;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    rd_idx        = root_r;
    req           = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.kind == KIND_LOAD) begin
            wr_en = (32'(in_data.node_index) < TREE_NODES);
          end else begin
            // Start a byte: fetch the root first
            byte_nxt  = in_data.stream_byte;
            last_nxt  = in_data.last_byte;
            rem_nxt   = in_data.last_byte ? REM_W'(BITS_PER_BYTE) - REM_W'(pad_r)
                                          : REM_W'(BITS_PER_BYTE);
            rd_en     = 1'b1;
            rd_idx    = root_r;
            state_nxt = ST_ROOT;
          end
        end
      end
      ST_ROOT: begin
        root_node_nxt = rd_node;
        if (rd_node.leaf) begin
          state_nxt = ST_RLEAF;
        end else begin
          rd_en     = 1'b1;
          rd_idx    = walk_r;
          state_nxt = ST_CUR;
        end
      end
      ST_CUR: begin
        // Take the first bit from the node the walk sits on
        rd_en     = 1'b1;
        rd_idx    = child;
        walk_nxt  = child;
        byte_nxt  = {byte_r[6:0], 1'b0};
        rem_nxt   = rem_r - REM_W'(1);
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        req.push   = rd_node.leaf;
        req.symbol = rd_node.symbol;
        if (!rd_node.leaf || req_ok) begin
          if (rd_node.leaf) begin
            walk_nxt = root_r;
          end
          if (rem_r != '0) begin
            rd_en    = 1'b1;
            rd_idx   = child;
            walk_nxt = child;
            byte_nxt = {byte_r[6:0], 1'b0};
            rem_nxt  = rem_r - REM_W'(1);
          end else begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_RLEAF: begin
        // Root is a leaf: every bit emits the root symbol
        req.push   = 1'b1;
        req.symbol = root_node_r.symbol;
        if (req_ok) begin
          walk_nxt = root_r;
          rem_nxt  = rem_r - REM_W'(1);
          if (rem_r == REM_W'(1)) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        // Tag the held symbol as the last of this byte; drop a partial code on the final byte
        req.fin = 1'b1;
        if (req_ok) begin
          if (last_r) begin
            walk_nxt = root_r;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_valid) begin
      priority case (cfg_index)
        REG_PADDING_BITS: pad_nxt = cfg_data[PAD_W-1:0];
        REG_ROOT_INDEX: begin
          root_nxt = cfg_data[IDX_W-1:0];
          walk_nxt = cfg_data[IDX_W-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pad_r   <= '0;
      root_r  <= '0;
      walk_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pad_r   <= pad_nxt;
      root_r  <= root_nxt;
      walk_r  <= walk_nxt;
    end
    byte_r      <= byte_nxt;
    rem_r       <= rem_nxt;
    last_r      <= last_nxt;
    root_node_r <= root_node_nxt;
    if (rd_en) begin
      rd_oob_r <= !(32'(rd_idx) < TREE_NODES);
    end
  end

endmodule

// ===== hw/rtl/htwd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module htwd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/htwd_out.sv =====
// Output stage: holds the newest symbol back until the next one or the run end tags it.
module htwd_out (
  input  logic                clk,
  input  logic                rst_n,
  input  htwd_pkg::emit_req_t req,
  output logic                req_ok,
  output logic                out_valid,
  input  logic                out_ready,
  output htwd_pkg::out_item_t out_data
);
  import htwd_pkg::*;

  logic             pend_v_r, pend_v_nxt;
  logic [SYM_W-1:0] pend_sym_r, pend_sym_nxt;
  logic             out_v_r, out_v_nxt;
  out_item_t        out_d_r, out_d_nxt;

  // A request can go through unless both the held symbol and the output register are full and the receiver is not ready
  assign req_ok = !pend_v_r || !out_v_r || out_ready;

  always_comb begin
    pend_v_nxt   = pend_v_r;
    pend_sym_nxt = pend_sym_r;
    out_v_nxt    = out_v_r && !out_ready;
    out_d_nxt    = out_d_r;
    if ((req.push || req.fin) && req_ok && pend_v_r) begin
      out_v_nxt                = 1'b1;
      out_d_nxt.decoded_symbol = pend_sym_r;
      out_d_nxt.last_in_run    = req.fin;
    end
    if (req.push && req_ok) begin
      pend_v_nxt   = 1'b1;
      pend_sym_nxt = req.symbol;
    end else if (req.fin && req_ok) begin
      pend_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
    pend_sym_r <= pend_sym_nxt;
    out_d_r    <= out_d_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

endmodule

// ===== hw/rtl/htwd_chk.sv =====
// Port-level checker for the Huffman tree-walk decoder, bound to the top level.
module htwd_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input htwd_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input htwd_pkg::out_item_t out_data
);
  import htwd_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // Reset empties the result side
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // An accepted stream byte drops in_ready in the next cycle
  a_stream_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.kind == KIND_STREAM |=> !in_ready)
    else $error("accepted an item during a byte walk");

  // A node load leaves the input ready in the next cycle
  a_load_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.kind == KIND_LOAD |=> in_ready)
    else $error("node load did not finish in one cycle");

endmodule

bind huffman_tree_walk_decoder htwd_chk u_htwd_chk (.*);

// ===== sim/testbench.sv =====
// Self-checking testbench for the Huffman tree-walk decoder: random trees, byte streams, stalls.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import htwd_pkg::*;

  localparam int TREE_NODES    = TREE_NODES_DEF;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 400;    // long receiver stall in the pressure test
  localparam int CYCLE_LIMIT   = 250000;

  // Register indexes the block does not decode; writes to them must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LOW  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HIGH = '1;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  huffman_tree_walk_decoder #(.TREE_NODES(TREE_NODES)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Decoder shadow state: node table, walk pointer and the two registers
  node_t            node_mem [TREE_NODES];
  logic [IDX_W-1:0] walk_pos  = '0;
  logic [IDX_W-1:0] root_cfg  = '0;
  logic [PAD_W-1:0] pad_cfg   = '0;

  // Symbols the block owes us, oldest first
  out_item_t        symbol_q [$];
  out_item_t        want;
  int               mismatches = 0;
  int               cycle_count = 0;

  // Slots of the tree currently loaded; slot_taken guards allocation while building
  logic [IDX_W-1:0] tree_slots [$];
  bit               slot_taken [TREE_NODES];

  // Idle rates in percent, and the toggle that starts a long receiver stall
  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;
  bit               hold_req = 1'b0;
  bit               hold_ack = 1'b0;
  int               hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Walk the shadow tree for one accepted item and queue the symbols it emits.
  // Load items only update the table; the walk pointer stays put.
  function automatic void decode_item(input in_item_t it);
    node_t     rt;
    node_t     cur;
    node_t     nxt;
    out_item_t res;
    int        nbits;
    int        emitted;
    if (it.kind == KIND_LOAD) begin
      node_mem[it.node_index] = node_t'{it.node_is_leaf, it.node_symbol,
                                        it.left_child, it.right_child};
      return;
    end
    nbits   = it.last_byte ? BITS_PER_BYTE - int'(pad_cfg) : BITS_PER_BYTE;
    emitted = 0;
    for (int i = 0; i < nbits; i++) begin
      rt = node_mem[root_cfg];
      if (rt.leaf) begin
        // Single-leaf tree: every bit yields the root symbol
        res.decoded_symbol = rt.symbol;
        res.last_in_run    = 1'b0;
        symbol_q.insert(symbol_q.size(), res);
        emitted++;
        walk_pos = root_cfg;
      end else begin
        cur      = node_mem[walk_pos];
        walk_pos = it.stream_byte[BITS_PER_BYTE-1-i] ? cur.right : cur.left;
        nxt      = node_mem[walk_pos];
        if (nxt.leaf) begin
          res.decoded_symbol = nxt.symbol;
          res.last_in_run    = 1'b0;
          symbol_q.insert(symbol_q.size(), res);
          emitted++;
          walk_pos = root_cfg;
        end
      end
    end
    // Final byte: drop any partial code and restart at the root
    if (it.last_byte) walk_pos = root_cfg;
    if (emitted > 0) symbol_q[symbol_q.size()-1].last_in_run = 1'b1;
  endfunction

  // Offer one item, idling at random first; leave valid high after acceptance
  // so back-to-back items keep the channel busy.
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    decode_item(it);
  endtask

  task automatic load_node(input logic [IDX_W-1:0] slot, input node_t nd);
    in_item_t it;
    it.kind         = KIND_LOAD;
    it.node_index   = slot;
    it.node_is_leaf = nd.leaf;
    it.node_symbol  = nd.symbol;
    it.left_child   = nd.left;
    it.right_child  = nd.right;
    // Stream fields are don't-care on a load; randomize them anyway
    it.stream_byte  = SYM_W'($urandom);
    it.last_byte    = 1'($urandom);
    send_item(it);
  endtask

  task automatic send_byte(input logic [SYM_W-1:0] data, input logic last);
    in_item_t it;
    it.kind         = KIND_STREAM;
    it.node_index   = IDX_W'($urandom);
    it.node_is_leaf = 1'($urandom);
    it.node_symbol  = SYM_W'($urandom);
    it.left_child   = IDX_W'($urandom);
    it.right_child  = IDX_W'($urandom);
    it.stream_byte  = data;
    it.last_byte    = last;
    send_item(it);
  endtask

  // Drop valid, wait for every owed symbol, then let a silent byte finish
  task automatic quiesce();
    in_valid <= 1'b0;
    while (symbol_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes happen only with the block idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    quiesce();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_PADDING_BITS: pad_cfg = val[PAD_W-1:0];
      REG_ROOT_INDEX: begin
        root_cfg = val[IDX_W-1:0];
        walk_pos = val[IDX_W-1:0];
      end
      default: ;
    endcase
  endtask

  function automatic logic [IDX_W-1:0] claim_slot();
    logic [IDX_W-1:0] s;
    do s = IDX_W'($urandom_range(TREE_NODES-1)); while (slot_taken[s]);
    slot_taken[s] = 1'b1;
    return s;
  endfunction

  function automatic logic [IDX_W-1:0] any_tree_slot();
    return tree_slots[$urandom_range(tree_slots.size()-1)];
  endfunction

  // Grow a random full binary tree by splitting leaves, then load its nodes
  // in random order. Every child index points into the tree, so no walk can
  // ever land on a slot that was never written.
  task automatic load_random_tree(input int n_leaves);
    node_t part [$];
    int    open_leaf [$];
    int    order [$];
    int    k;
    int    p;
    int    a;
    tree_slots.delete();
    foreach (slot_taken[i]) slot_taken[i] = 1'b0;
    tree_slots.insert(tree_slots.size(), claim_slot());
    part.insert(part.size(), '0);
    open_leaf.insert(open_leaf.size(), 0);
    while (open_leaf.size() < n_leaves) begin
      k = $urandom_range(open_leaf.size()-1);
      p = open_leaf[k];
      open_leaf.delete(k);
      a = tree_slots.size();
      tree_slots.insert(tree_slots.size(), claim_slot());
      tree_slots.insert(tree_slots.size(), claim_slot());
      part.insert(part.size(), '0);
      part.insert(part.size(), '0);
      part[p].left  = tree_slots[a];
      part[p].right = tree_slots[a+1];
      open_leaf.insert(open_leaf.size(), a);
      open_leaf.insert(open_leaf.size(), a + 1);
    end
    foreach (open_leaf[i]) part[open_leaf[i]].leaf = 1'b1;
    foreach (part[i]) begin
      part[i].symbol = SYM_W'($urandom);
      if (part[i].leaf) begin
        part[i].left  = any_tree_slot();
        part[i].right = any_tree_slot();
      end
      order.insert(order.size(), i);
    end
    while (order.size() != 0) begin
      k = $urandom_range(order.size()-1);
      load_node(tree_slots[order[k]], part[order[k]]);
      order.delete(k);
    end
  endtask

  // Noise load: mostly relabel a tree node in place, sometimes overwrite any
  // slot with random content whose children stay inside the tree.
  task automatic send_noise_load();
    logic [IDX_W-1:0] slot;
    node_t            nd;
    if ($urandom_range(3) != 0) begin
      slot      = any_tree_slot();
      nd        = node_mem[slot];
      nd.symbol = SYM_W'($urandom);
    end else begin
      slot = IDX_W'($urandom_range(TREE_NODES-1));
      nd   = node_t'{1'($urandom), SYM_W'($urandom), any_tree_slot(), any_tree_slot()};
    end
    load_node(slot, nd);
  endtask

  task automatic send_random_byte();
    send_byte(SYM_W'($urandom), $urandom_range(5) == 0);
  endtask

  // Hand-built three-leaf tree at the table extremes:
  //   root 511 -> left leaf 0 (0x00), right 256 -> left leaf 1 (0xFF),
  //   right leaf 510 (0xA5). Codes: 0, 10, 11.
  task automatic test_directed();
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    write_reg(REG_PADDING_BITS, CFG_DATA_W'(0));
    write_reg(REG_ROOT_INDEX, CFG_DATA_W'(511));
    // Unknown indexes must leave both registers alone
    write_reg(REG_SPARE_LOW, '1);
    write_reg(REG_SPARE_HIGH, '0);
    load_node(IDX_W'(511), node_t'{1'b0, 8'h00, IDX_W'(0), IDX_W'(256)});
    load_node(IDX_W'(0),   node_t'{1'b1, 8'h00, IDX_W'(511), IDX_W'(511)});
    load_node(IDX_W'(256), node_t'{1'b0, 8'hFF, IDX_W'(1), IDX_W'(510)});
    load_node(IDX_W'(1),   node_t'{1'b1, 8'hFF, IDX_W'(0), IDX_W'(0)});
    load_node(IDX_W'(510), node_t'{1'b1, 8'hA5, IDX_W'(511), IDX_W'(511)});
    send_byte(8'hFF, 1'b0);      // four two-bit codes
    send_byte(8'h00, 1'b0);      // eight one-bit codes: the most per byte
    send_byte(8'h01, 1'b0);      // ends halfway down a code
    // Relabel a leaf while the walk is parked mid-code
    load_node(IDX_W'(510), node_t'{1'b1, 8'h3C, IDX_W'(511), IDX_W'(511)});
    send_byte(8'h7F, 1'b0);      // finishes the carried code first
    write_reg(REG_PADDING_BITS, CFG_DATA_W'(7));
    send_byte(8'hC0, 1'b1);      // one live bit completes the carried code
    send_byte(8'h80, 1'b1);      // one live bit, partial code dropped: no symbol
    write_reg(REG_PADDING_BITS, CFG_DATA_W'(3));
    send_byte(8'h50, 1'b1);      // live bits end exactly on a code boundary
    write_reg(REG_PADDING_BITS, CFG_DATA_W'(0));
    send_byte(8'hAA, 1'b1);
    // Root that is itself a leaf: every bit yields its symbol
    write_reg(REG_ROOT_INDEX, CFG_DATA_W'(0));
    send_byte(8'h5A, 1'b0);
    write_reg(REG_PADDING_BITS, CFG_DATA_W'(7));
    send_byte(8'h33, 1'b1);
    write_reg(REG_ROOT_INDEX, CFG_DATA_W'(511));
    send_byte(8'h96, 1'b1);
  endtask

  // One random phase: fresh tree, fresh registers, mostly stream bytes with
  // a sprinkling of node loads, and a padding change halfway through.
  task automatic test_random_phase(input int snd_pct, input int rcv_pct,
                                   input int n_items, input int pad);
    send_idle_pct = snd_pct;
    recv_idle_pct <= rcv_pct;
    load_random_tree(($urandom_range(9) == 0) ? 1 : $urandom_range(2, 16));
    write_reg(REG_PADDING_BITS, CFG_DATA_W'(pad));
    write_reg(REG_ROOT_INDEX, CFG_DATA_W'(tree_slots[0]));
    for (int i = 0; i < n_items; i++) begin
      if (i == n_items / 2) write_reg(REG_PADDING_BITS, CFG_DATA_W'($urandom_range(7)));
      if ($urandom_range(9) == 0) send_noise_load();
      else send_random_byte();
    end
  endtask

  // Stall the receiver for a long stretch while bytes keep coming, so the
  // block backs up into its input; then pause the sender until it drains.
  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    load_random_tree($urandom_range(8, 16));
    write_reg(REG_PADDING_BITS, CFG_DATA_W'($urandom_range(7)));
    write_reg(REG_ROOT_INDEX, CFG_DATA_W'(tree_slots[0]));
    hold_req <= ~hold_req;
    repeat (40) send_random_byte();
    quiesce();
    repeat (20) send_random_byte();
  endtask

  // Receiver: random ready, overridden by a counted hold when requested
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each accepted symbol with the oldest one owed
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (symbol_q.size() == 0) begin
        $error("decoded_symbol: expected none, got %0h", out_data.decoded_symbol);
        mismatches++;
      end else begin
        want = symbol_q.pop_front();
        if (out_data.decoded_symbol !== want.decoded_symbol) begin
          $error("decoded_symbol: expected %0h, got %0h",
                 want.decoded_symbol, out_data.decoded_symbol);
          mismatches++;
        end
        if (out_data.last_in_run !== want.last_in_run) begin
          $error("last_in_run: expected %0b, got %0b",
                 want.last_in_run, out_data.last_in_run);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    foreach (node_mem[i]) node_mem[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_phase(11, 49, 80, 7);
    test_random_phase(49, 11, 80, 0);
    test_random_phase(0, 0, 50, $urandom_range(7));
    test_output_stall();
    quiesce();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/htwd_pkg.sv
hw/rtl/htwd_ram.sv
hw/rtl/htwd_out.sv
hw/rtl/huffman_tree_walk_decoder.sv
hw/rtl/htwd_chk.sv
sim/testbench.sv
